// File: rtl/core/prolog_clause_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// prolog clause tokenizer assertion macros
// shared assertion wrappers for the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef PROLOG_CLAUSE_TOKENIZER_DEFINES_SVH
`define PROLOG_CLAUSE_TOKENIZER_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define PCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PCT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// shared types, character codes and class codes of the clause tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pct_pkg;

   // default width of the nesting depth counter
   localparam int DEPTH_BITS_DEF = 16;

   // token class codes
   localparam logic [3:0] CLS_TERM      = 4'd0;
   localparam logic [3:0] CLS_FACT_END  = 4'd1;
   localparam logic [3:0] CLS_OPEN      = 4'd2;
   localparam logic [3:0] CLS_CLOSE     = 4'd3;
   localparam logic [3:0] CLS_CONJ      = 4'd4;
   localparam logic [3:0] CLS_SEPARATOR = 4'd5;
   localparam logic [3:0] CLS_NECK      = 4'd6;
   localparam logic [3:0] CLS_UNKNOWN   = 4'd7;
   localparam logic [3:0] CLS_END       = 4'd8;

   // character codes
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_PERIOD     = 8'h2E;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_BAR        = 8'h7C;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_DEL        = 8'h7F;
   localparam logic [7:0] CH_NUL        = 8'h00;

   // one result word
   typedef struct packed {
      logic [3:0]  token_class;
      logic [7:0]  char_value;
      logic        term_start;
      logic [15:0] nesting_depth;
      logic [31:0] line_count;
   } result_type;

   // single-bit scanner state
   typedef struct packed {
      logic in_comment;
      logic colon_pending;
      logic in_term;
   } flags_type;

   // control byte: below space or delete
   function automatic logic is_ctrl(input logic [7:0] c);
      return (c < CH_SPACE) || (c == CH_DEL);
   endfunction

   // blank: space or tab through carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // letters, digits, underscore, open bracket, bang
   function automatic logic is_term_char(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) ||
             (c == CH_UNDERSCORE) || (c == CH_LBRACKET) || (c == CH_BANG);
   endfunction

endpackage

// File: rtl/core/prolog_clause_tokenizer.sv
// path: a byte accepted on req waits in the input register, moves on into the
//   result register and from there is offered on rsp
// throughput: one byte per cycle while rsp is not stalled; a byte behind a held
//   colon that is no neck and has its own word gives two words and stalls input
// an empty input register takes a byte while the result register waits on rsp_tready
// reset (synchronous, active high) clears depth, line count, all scanner flags
//   and the valid bit and word count of the pipeline registers
// ----------------------------------------------------------------------------
// prolog_clause_tokenizer
// classifies source text bytes into clause tokens for a clause parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prolog_clause_tokenizer
   import pct_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] char_value, [8] term_start,
                                    // [24:9] nesting_depth, [56:25] line_count,
                                    // [63:57] zero
   output logic [3:0]  rsp_tuser,   // [3:0] token_class
   output logic        rsp_tlast    // last_of_run
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_end_ff;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [31:0]           lines_ff, lines_in;
   flags_type             flags_ff, flags_in;
   result_type            res0_ff, res1_ff;
   logic [1:0]            cnt_ff, cnt_in;

   result_type            res_first, res_second, res_out;
   logic [1:0]            res_count;
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  out_free;
   logic                  advance;

   // handshakes
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign out_free   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // input register
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   // classification
   pct_classify #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_classify (
      .text_byte   (in_byte_ff),
      .end_of_text (in_end_ff),
      .flags       (flags_ff),
      .depth       (depth_ff),
      .lines       (lines_ff),
      .flags_next  (flags_in),
      .depth_next  (depth_in),
      .lines_next  (lines_in),
      .res_first   (res_first),
      .res_second  (res_second),
      .res_count   (res_count)
   );

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         lines_ff <= '0;
         flags_ff <= '0;
      end else if (advance) begin
         depth_ff <= depth_in;
         lines_ff <= lines_in;
         flags_ff <= flags_in;
      end
   end

   // result register: words left to send
   always_comb begin
      cnt_in = cnt_ff;
      if (advance) begin
         cnt_in = res_count;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res0_ff <= res_first;
         res1_ff <= res_second;
      end
   end

   // output word select
   assign res_out    = (cnt_ff == 2'd2) ? res0_ff : res1_ff;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tlast  = (cnt_ff == 2'd1);
   assign rsp_tuser  = res_out.token_class;
   assign rsp_tdata  = {7'd0, res_out.line_count, res_out.nesting_depth,
                        res_out.term_start, res_out.char_value};

endmodule

// File: rtl/core/pct_classify.sv
// ----------------------------------------------------------------------------
// pct_classify
// per-byte classification: next scanner state and up to two result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_classify
   import pct_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  logic [7:0]            text_byte,
   input  logic                  end_of_text,
   input  flags_type             flags,
   input  logic [DEPTH_BITS-1:0] depth,
   input  logic [31:0]           lines,
   output flags_type             flags_next,
   output logic [DEPTH_BITS-1:0] depth_next,
   output logic [31:0]           lines_next,
   output result_type            res_first,
   output result_type            res_second,
   output logic [1:0]            res_count
);

   localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

   logic       neck;
   logic       take;
   logic       held_unknown;
   logic       line_inc;
   logic       tb_emit;
   logic [3:0] tb_class;
   logic       tb_start;
   logic       prim_emit;
   result_type prim_res;
   result_type colon_res;

   // path decode: neck closes a held colon, otherwise the byte is scanned
   assign neck         = !end_of_text && flags.colon_pending && (text_byte == CH_MINUS);
   assign take         = !end_of_text && !neck;
   assign held_unknown = flags.colon_pending && !neck;

   // line counting: control byte when scanned, or end of text inside a comment
   assign line_inc   = end_of_text ? flags.in_comment : (take && is_ctrl(text_byte));
   assign lines_next = (line_inc && (lines != 32'hFFFF_FFFF)) ? lines + 32'd1 : lines;

   // byte scanner
   always_comb begin
      tb_emit    = 1'b0;
      tb_class   = CLS_UNKNOWN;
      tb_start   = 1'b0;
      flags_next = flags;
      depth_next = depth;
      flags_next.colon_pending = 1'b0;
      if (end_of_text) begin
         flags_next.in_comment = 1'b0;
         flags_next.in_term    = 1'b0;
      end else if (take) begin
         priority if (flags.in_comment) begin
            if (is_ctrl(text_byte)) begin
               flags_next.in_comment = 1'b0;
            end
         end else if (is_term_char(text_byte)) begin
            tb_emit  = 1'b1;
            tb_class = CLS_TERM;
            tb_start = !flags.in_term;
            // a bracket that opens a term stands alone
            flags_next.in_term = !((text_byte == CH_LBRACKET) && !flags.in_term);
         end else begin
            flags_next.in_term = 1'b0;
            priority if (text_byte == CH_PERCENT) begin
               flags_next.in_comment = 1'b1;
            end else if (is_space(text_byte)) begin
               tb_emit = 1'b0;
            end else begin
               tb_emit = 1'b1;
               unique case (text_byte)
                  CH_PERIOD: begin
                     tb_class = CLS_FACT_END;
                  end
                  CH_LPAREN: begin
                     tb_class = CLS_OPEN;
                     if (depth != DepthMax) depth_next = depth + DepthOne;
                  end
                  CH_RPAREN: begin
                     tb_class = CLS_CLOSE;
                     if (depth != '0) depth_next = depth - DepthOne;
                  end
                  CH_RBRACKET: begin
                     tb_class = CLS_CLOSE;
                  end
                  CH_COMMA, CH_BAR: begin
                     tb_class = (depth == '0) ? CLS_CONJ : CLS_SEPARATOR;
                  end
                  CH_COLON: begin
                     tb_emit = 1'b0;
                     flags_next.colon_pending = 1'b1;
                  end
                  default: begin
                     tb_class = CLS_UNKNOWN;
                  end
               endcase
            end
         end
      end
   end

   // result carried by the byte itself, or the neck or end marker
   always_comb begin
      prim_emit              = 1'b1;
      prim_res.token_class   = tb_class;
      prim_res.char_value    = text_byte;
      prim_res.term_start    = tb_start;
      prim_res.nesting_depth = 16'(depth_next);
      prim_res.line_count    = lines_next;
      priority if (end_of_text) begin
         prim_res.token_class = CLS_END;
         prim_res.char_value  = CH_NUL;
         prim_res.term_start  = 1'b0;
      end else if (neck) begin
         prim_res.token_class = CLS_NECK;
         prim_res.char_value  = CH_COLON;
         prim_res.term_start  = 1'b0;
      end else begin
         prim_emit = tb_emit;
      end
   end

   // held colon that turned out not to be a neck, seen before the byte's effect
   always_comb begin
      colon_res.token_class   = CLS_UNKNOWN;
      colon_res.char_value    = CH_COLON;
      colon_res.term_start    = 1'b0;
      colon_res.nesting_depth = 16'(depth);
      colon_res.line_count    = lines;
   end

   // pack: the last result of a byte always sits in the second slot
   assign res_first  = colon_res;
   assign res_second = prim_emit ? prim_res : colon_res;
   assign res_count  = {1'b0, held_unknown} + {1'b0, prim_emit};

endmodule

// File: rtl/core/pct_checker.sv
// ----------------------------------------------------------------------------
// pct_checker
// port-level checks of the clause tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prolog_clause_tokenizer_defines.svh"

module pct_checker
   import pct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic stalled;
   logic end_word;
   logic term_word;

   assign stalled   = rsp_tvalid && !rsp_tready;
   assign end_word  = rsp_tvalid && (rsp_tuser == CLS_END);
   assign term_word = (rsp_tuser == CLS_TERM);

   // a stalled word holds
   `PCT_ASSERT(a_rsp_hold, clock, reset, stalled |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result word changed")

   // nothing leaves right after reset
   `PCT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // end marker is always the last word of its byte and carries no character
   `PCT_ASSERT(a_end_shape, clock, reset, end_word |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0), "bad end marker word")

   // only term words may open a term
   `PCT_ASSERT(a_start_term, clock, reset, (rsp_tvalid && !term_word) |-> !rsp_tdata[8], "term start on non-term word")

   // line count never goes back between words that follow each other
   `PCT_ASSERT(a_lines_up, clock, reset, (rsp_tvalid && $past(rsp_tvalid) && !$past(reset)) |-> (rsp_tdata[56:25] >= $past(rsp_tdata[56:25])), "line count went down")

endmodule

bind prolog_clause_tokenizer pct_checker u_pct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
